// ----- hw/rtl/bdq_pkg.sv -----
package bdq_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned ValueW  = 31;
  localparam int unsigned AnswerW = 32;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SIZE       = 3'd4,
    OP_EMPTY      = 3'd5,
    OP_FRONT      = 3'd6,
    OP_BACK       = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic exec;      // request transfer this cycle
    logic take_mem;  // latch memory read data as the answer
  } cmd_t;

  // datapath -> controller, describes the request at the input
  typedef struct packed {
    logic needs_read;
    logic has_result;
  } stat_t;

endpackage

// ----- hw/rtl/bdq_ctrl.sv -----
module bdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bdq_pkg::stat_t stat_i,
  output bdq_pkg::cmd_t  cmd_o
);
  import bdq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          if (stat_i.needs_read) begin
            state_d = ST_READ;
          end else if (stat_i.has_result) begin
            state_d = ST_RESP;
          end
        end
      end
      ST_READ: begin
        cmd_o.take_mem = 1'b1;
        state_d        = ST_RESP;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/bdq_datapath.sv -----
module bdq_datapath #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [bdq_pkg::OpW-1:0]             operation_i,
  input  logic [bdq_pkg::ValueW-1:0]          value_i,
  output logic signed [bdq_pkg::AnswerW-1:0]  answer_o,
  input  bdq_pkg::cmd_t                       cmd_i,
  output bdq_pkg::stat_t                      stat_o
);
  import bdq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [AnswerW-1:0]    ans_q, ans_d;
  logic [IdxW-1:0]       head_q, head_d;
  logic [CntW-1:0]       count_q, count_d;

  op_e              op;
  logic             empty, full;
  logic [IdxW-1:0]  head_inc, head_dec, back_pos, tail_pos;
  logic [SumW-1:0]  sum, sum_m1;
  logic             wr_en, rd_en;
  logic [IdxW-1:0]  waddr, raddr;

  assign op    = op_e'(operation_i);
  assign empty = (count_q == '0);
  assign full  = (count_q == CntW'(DEPTH));

  assign head_inc = (head_q == IdxW'(DEPTH - 1)) ? '0 : head_q + IdxW'(1);
  assign head_dec = (head_q == '0) ? IdxW'(DEPTH - 1) : head_q - IdxW'(1);

  // head + count stays below 2*DEPTH, one conditional subtract wraps it
  assign sum    = SumW'(head_q) + SumW'(count_q);
  assign sum_m1 = sum - SumW'(1);
  assign back_pos = (sum >= SumW'(DEPTH)) ? IdxW'(sum - SumW'(DEPTH)) : IdxW'(sum);
  assign tail_pos = (sum_m1 >= SumW'(DEPTH)) ? IdxW'(sum_m1 - SumW'(DEPTH))
                                             : IdxW'(sum_m1);

  always_comb begin
    stat_o.needs_read = 1'b0;
    stat_o.has_result = 1'b1;
    head_d  = head_q;
    count_d = count_q;
    ans_d   = ans_q;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    waddr   = back_pos;
    raddr   = head_q;
    case (op)
      OP_PUSH_FRONT: begin
        stat_o.has_result = 1'b0;
        if (!full) begin
          wr_en   = cmd_i.exec;
          waddr   = head_dec;
          head_d  = head_dec;
          count_d = count_q + CntW'(1);
        end
      end
      OP_PUSH_BACK: begin
        stat_o.has_result = 1'b0;
        if (!full) begin
          wr_en   = cmd_i.exec;
          count_d = count_q + CntW'(1);
        end
      end
      OP_POP_FRONT, OP_FRONT: begin
        if (empty) begin
          ans_d = '1;
        end else begin
          stat_o.needs_read = 1'b1;
          rd_en             = cmd_i.exec;
          if (op == OP_POP_FRONT) begin
            head_d  = head_inc;
            count_d = count_q - CntW'(1);
          end
        end
      end
      OP_POP_BACK, OP_BACK: begin
        raddr = tail_pos;
        if (empty) begin
          ans_d = '1;
        end else begin
          stat_o.needs_read = 1'b1;
          rd_en             = cmd_i.exec;
          if (op == OP_POP_BACK) begin
            count_d = count_q - CntW'(1);
          end
        end
      end
      OP_SIZE: begin
        ans_d = AnswerW'(count_q);
      end
      OP_EMPTY: begin
        ans_d = AnswerW'(empty);
      end
      default: begin
        stat_o.has_result = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ans_q <= ans_d;
    end else if (cmd_i.take_mem) begin
      ans_q <= AnswerW'(rdata_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= DATA_WIDTH'(value_i);
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  assign answer_o = ans_q;

endmodule

// ----- hw/rtl/bounded_deque.sv -----
// channel | direction | handshake                | payload
// request | in        | in_valid_i / in_ready_o  | operation_i, value_i
// result  | out       | out_valid_o / out_ready_i| answer_o
//
// One request at a time. A push gives no result. Size, empty and pops or
// peeks on an empty queue answer from the answer register; pops and peeks on a
// non-empty queue first pass through the registered read of the ring memory.
// A result holds until its transfer; no request is taken meanwhile.
// Reset clears head and count; the ring memory itself is not cleared.
module bounded_deque #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bdq_pkg::OpW-1:0]             operation_i,
  input  logic [bdq_pkg::ValueW-1:0]          value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bdq_pkg::AnswerW-1:0]  answer_o
);
  import bdq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .operation_i (operation_i),
    .value_i     (value_i),
    .answer_o    (answer_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
